FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clk, off during rst.
`define AMIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define AMIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/amie_pkg.sv
// ----------------------------------------------------------------------------
// amie_pkg
// Shared codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package amie_pkg;

  localparam logic [1:0] ST_RAN     = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FAULT   = 2'd3;

  localparam logic [3:0] OP_CMOV   = 4'd0;
  localparam logic [3:0] OP_INDEX  = 4'd1;
  localparam logic [3:0] OP_AMEND  = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_MUL    = 4'd4;
  localparam logic [3:0] OP_DIV    = 4'd5;
  localparam logic [3:0] OP_NAND   = 4'd6;
  localparam logic [3:0] OP_HALT   = 4'd7;
  localparam logic [3:0] OP_NEWARR = 4'd8;
  localparam logic [3:0] OP_ABAND  = 4'd9;
  localparam logic [3:0] OP_OUT    = 4'd10;
  localparam logic [3:0] OP_IN     = 4'd11;
  localparam logic [3:0] OP_LDPRG  = 4'd12;
  localparam logic [3:0] OP_ORTH   = 4'd13;

  localparam logic [4:0] A_NONE    = 5'd0;
  localparam logic [4:0] A_ACCEPT  = 5'd1;
  localparam logic [4:0] A_LOAD    = 5'd2;
  localparam logic [4:0] A_FETCH   = 5'd3;
  localparam logic [4:0] A_OPLAT   = 5'd4;
  localparam logic [4:0] A_RDA     = 5'd5;
  localparam logic [4:0] A_RDB     = 5'd6;
  localparam logic [4:0] A_RDC     = 5'd7;
  localparam logic [4:0] A_EXEC    = 5'd8;
  localparam logic [4:0] A_LENRD   = 5'd9;
  localparam logic [4:0] A_RDST    = 5'd10;
  localparam logic [4:0] A_RDLAT   = 5'd11;
  localparam logic [4:0] A_AMEND   = 5'd12;
  localparam logic [4:0] A_DIVST   = 5'd13;
  localparam logic [4:0] A_DIV     = 5'd14;
  localparam logic [4:0] A_DIVWR   = 5'd15;
  localparam logic [4:0] A_FSRD    = 5'd16;
  localparam logic [4:0] A_SPOP    = 5'd17;
  localparam logic [4:0] A_SFRESH  = 5'd18;
  localparam logic [4:0] A_CLR     = 5'd19;
  localparam logic [4:0] A_ALLOCFN = 5'd20;
  localparam logic [4:0] A_ABANDON = 5'd21;
  localparam logic [4:0] A_CSET    = 5'd22;
  localparam logic [4:0] A_CRD     = 5'd23;
  localparam logic [4:0] A_CWR     = 5'd24;
  localparam logic [4:0] A_CFIN    = 5'd25;
  localparam logic [4:0] A_JUMP    = 5'd26;

  typedef struct packed {
    logic [4:0] act;
    logic       fin;
    logic [1:0] fin_status;
  } cmd_t;

  typedef struct packed {
    logic       is_load;
    logic       halted;
    logic       pc_ok;
    logic [3:0] opc;
    logic       vb_zero;
    logic       vc_zero;
    logic       out_bad;
    logic       alloc_bad;
    logic       free_nonempty;
    logic       fresh_avail;
    logic       abandon_bad;
    logic       slot_ok;
    logic       off_ok;
    logic       jump_bad;
    logic       cnt_done;
    logic       div_done;
    logic       res_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/amie_ram.sv
// ----------------------------------------------------------------------------
// amie_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module amie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/amie_dp.sv
// ----------------------------------------------------------------------------
// amie_dp
// Datapath: registers, pc, slot bookkeeping, divider, array store.
// ----------------------------------------------------------------------------
`default_nettype none
module amie_dp import amie_pkg::*; #(
  parameter int NUM_SLOTS  = 64,
  parameter int SLOT_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        opcode,
  input  wire logic [11:0] load_address,
  input  wire logic [31:0] load_word,
  input  wire logic        load_last,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_eof,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [1:0]       status,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             input_taken,
  output logic [11:0]      next_pc
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int OW = $clog2(SLOT_WORDS);
  localparam int LW = $clog2(SLOT_WORDS + 1);
  localparam int AW = SW + OW;
  localparam int STORE_DEPTH = NUM_SLOTS * (2 ** OW);

  logic        q_opcode;
  logic [11:0] q_addr;
  logic [31:0] q_word;
  logic        q_last;
  logic [7:0]  q_char;
  logic        q_eof;

  logic [31:0] rf [8];
  logic [31:0] op, va, vb, vc;
  logic [LW-1:0] pc, len0, k, lim;
  logic          halted;
  logic [NUM_SLOTS-1:0] active;
  logic [CW-1:0] free_count, next_fresh;
  logic [SW-1:0] sreg;
  logic [31:0]   quo, rem;
  logic [5:0]    dcnt;
  logic          ov, tk;
  logic [7:0]    oc;

  logic [3:0] opc;
  logic [2:0] ia, ib, ic, ridx, widx;
  logic [31:0] rdv, wdat;
  logic        rwe;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [31:0]   st_wdata, st_rdata;
  logic [LW-1:0] lr_rdata, slen;
  logic [SW-1:0] fs_rdata;
  logic [CW-1:0] fc_m1;

  logic [31:0] sel_slot, sel_off;
  logic        sel_ok, vc_ok, addr_ok, pc_inc;
  logic [32:0] rem_sh, diff;

  assign opc = op[31:28];
  assign ia  = op[8:6];
  assign ib  = op[5:3];
  assign ic  = op[2:0];

  assign addr_ok  = {20'b0, q_addr} < 32'(SLOT_WORDS);
  assign sel_slot = (opc == OP_AMEND) ? va : vb;
  assign sel_off  = (opc == OP_AMEND) ? vb : vc;
  assign sel_ok   = (sel_slot < 32'(NUM_SLOTS)) && active[sel_slot[SW-1:0]];
  assign vc_ok    = (vc < 32'(NUM_SLOTS)) && active[vc[SW-1:0]];
  assign slen     = (sel_slot == 32'd0) ? len0 : lr_rdata;
  assign fc_m1    = free_count - CW'(1);
  assign rem_sh   = {rem, quo[31]};
  assign diff     = rem_sh - {1'b0, vc};

  always_comb begin
    case (cmd.act)
      A_RDA:   ridx = ia;
      A_RDB:   ridx = ib;
      default: ridx = ic;
    endcase
    rdv = rf[ridx];
  end

  always_comb begin
    rwe  = 1'b0;
    widx = ia;
    wdat = vb;
    case (cmd.act)
      A_EXEC: begin
        case (opc)
          OP_CMOV: rwe = (vc != 32'd0);
          OP_ADD: begin
            rwe  = 1'b1;
            wdat = vb + vc;
          end
          OP_MUL: begin
            rwe  = 1'b1;
            wdat = vb * vc;
          end
          OP_NAND: begin
            rwe  = 1'b1;
            wdat = ~(vb & vc);
          end
          OP_IN: begin
            rwe  = 1'b1;
            widx = ic;
            wdat = q_eof ? 32'hFFFF_FFFF : {24'b0, q_char};
          end
          OP_ORTH: begin
            rwe  = 1'b1;
            widx = op[27:25];
            wdat = {7'b0, op[24:0]};
          end
          default: rwe = 1'b0;
        endcase
      end
      A_RDLAT: begin
        rwe  = 1'b1;
        wdat = st_rdata;
      end
      A_DIVWR: begin
        rwe  = 1'b1;
        wdat = quo;
      end
      A_ALLOCFN: begin
        rwe  = 1'b1;
        widx = ib;
        wdat = 32'(sreg);
      end
      default: rwe = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.act)
      A_EXEC, A_RDLAT, A_AMEND, A_DIVWR, A_ALLOCFN, A_ABANDON: pc_inc = 1'b1;
      default: pc_inc = 1'b0;
    endcase
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = {SW'(0), OW'(q_addr)};
    st_wdata = q_word;
    case (cmd.act)
      A_LOAD: st_we = addr_ok;
      A_AMEND: begin
        st_we    = 1'b1;
        st_waddr = {va[SW-1:0], vb[OW-1:0]};
        st_wdata = vc;
      end
      A_CLR: begin
        st_we    = 1'b1;
        st_waddr = {sreg, k[OW-1:0]};
        st_wdata = 32'd0;
      end
      A_CWR: begin
        st_we    = 1'b1;
        st_waddr = {SW'(0), k[OW-1:0]};
        st_wdata = st_rdata;
      end
      default: st_we = 1'b0;
    endcase
    case (cmd.act)
      A_RDST:  st_raddr = {vb[SW-1:0], vc[OW-1:0]};
      A_CRD:   st_raddr = {vb[SW-1:0], k[OW-1:0]};
      default: st_raddr = {SW'(0), pc[OW-1:0]};
    endcase
  end

  amie_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  amie_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_len (
    .clk(clk), .we(cmd.act == A_ALLOCFN), .waddr(sreg), .wdata(lim),
    .raddr(sel_slot[SW-1:0]), .rdata(lr_rdata)
  );

  amie_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_free (
    .clk(clk), .we(cmd.act == A_ABANDON), .waddr(free_count[SW-1:0]),
    .wdata(vc[SW-1:0]), .raddr(fc_m1[SW-1:0]), .rdata(fs_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.act == A_ACCEPT) begin
      q_opcode <= opcode;
      q_addr   <= load_address;
      q_word   <= load_word;
      q_last   <= load_last;
      q_char   <= in_char;
      q_eof    <= in_eof;
    end
    if (cmd.act == A_OPLAT) op <= st_rdata;
    if (cmd.act == A_RDA) va <= rdv;
    if (cmd.act == A_RDB) vb <= rdv;
    if (cmd.act == A_RDC) vc <= rdv;
    case (cmd.act)
      A_DIVST: begin
        quo  <= vb;
        rem  <= 32'd0;
        dcnt <= 6'd0;
      end
      A_DIV: begin
        dcnt <= dcnt + 6'd1;
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          quo <= {quo[30:0], 1'b0};
        end
      end
      A_SPOP: begin
        sreg <= fs_rdata;
        k    <= '0;
        lim  <= LW'(vc);
      end
      A_SFRESH: begin
        sreg <= next_fresh[SW-1:0];
        k    <= '0;
        lim  <= LW'(vc);
      end
      A_CSET: begin
        k   <= '0;
        lim <= slen;
      end
      A_CLR, A_CWR: k <= k + LW'(1);
      default: ;
    endcase
    if (cmd.fin) begin
      status      <= cmd.fin_status;
      out_valid   <= ov;
      out_char    <= oc;
      input_taken <= tk;
      next_pc     <= 12'(pc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) rf[i] <= 32'd0;
      pc           <= '0;
      len0         <= '0;
      halted       <= 1'b0;
      active       <= NUM_SLOTS'(1);
      free_count   <= '0;
      next_fresh   <= CW'(1);
      ov           <= 1'b0;
      oc           <= 8'd0;
      tk           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rwe) rf[widx] <= wdat;
      if (pc_inc) pc <= pc + LW'(1);
      case (cmd.act)
        A_ACCEPT: begin
          ov <= 1'b0;
          oc <= 8'd0;
          tk <= 1'b0;
        end
        A_LOAD: begin
          if (q_last) begin
            len0   <= addr_ok ? LW'(q_addr) + LW'(1) : LW'(SLOT_WORDS);
            pc     <= '0;
            halted <= 1'b0;
          end
        end
        A_EXEC: begin
          if (opc == OP_OUT) begin
            ov <= 1'b1;
            oc <= vc[7:0];
          end
          if (opc == OP_IN) tk <= 1'b1;
        end
        A_FSRD:    free_count <= fc_m1;
        A_SFRESH:  next_fresh <= next_fresh + CW'(1);
        A_ALLOCFN: active[sreg] <= 1'b1;
        A_ABANDON: begin
          active[vc[SW-1:0]] <= 1'b0;
          free_count         <= free_count + CW'(1);
        end
        A_CFIN:    len0 <= lim;
        A_JUMP:    pc <= LW'(vc);
        default: ;
      endcase
      if (cmd.fin) begin
        result_valid <= 1'b1;
        if (cmd.fin_status != ST_RAN) halted <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_load       = !q_opcode;
    sts.halted        = halted;
    sts.pc_ok         = pc < len0;
    sts.opc           = opc;
    sts.vb_zero       = (vb == 32'd0);
    sts.vc_zero       = (vc == 32'd0);
    sts.out_bad       = (vc > 32'd255);
    sts.alloc_bad     = (vc > 32'(SLOT_WORDS));
    sts.free_nonempty = (free_count != '0);
    sts.fresh_avail   = (next_fresh < CW'(NUM_SLOTS));
    sts.abandon_bad   = (vc == 32'd0) || !vc_ok || (free_count >= CW'(NUM_SLOTS));
    sts.slot_ok       = sel_ok;
    sts.off_ok        = sel_off < 32'(slen);
    sts.jump_bad      = vc >= 32'(len0);
    sts.cnt_done      = (k == lim);
    sts.div_done      = (dcnt == 6'd32);
    sts.res_free      = !result_valid || result_ready;
  end

endmodule
`default_nettype wire

FILE: rtl/amie_ctrl.sv
// ----------------------------------------------------------------------------
// amie_ctrl
// Sequencer: handles program loads and steps each instruction through fetch, operand read and execute.
// ----------------------------------------------------------------------------
`default_nettype none
module amie_ctrl import amie_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_OPLAT  = 4'd2;
  localparam logic [3:0] S_RDA    = 4'd3;
  localparam logic [3:0] S_RDB    = 4'd4;
  localparam logic [3:0] S_RDC    = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_RLAT   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_FSWAIT = 4'd10;
  localparam logic [3:0] S_ACLR   = 4'd11;
  localparam logic [3:0] S_CRD    = 4'd12;
  localparam logic [3:0] S_CWR    = 4'd13;
  localparam logic [3:0] S_JCHK   = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0] state, state_next;
  logic [1:0] st_q, st_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    st_next        = st_q;
    cmd.act        = A_NONE;
    cmd.fin        = 1'b0;
    cmd.fin_status = st_q;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act    = A_ACCEPT;
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = S_DONE;
        if (sts.is_load) begin
          cmd.act = A_LOAD;
          st_next = ST_RAN;
        end else if (sts.halted) begin
          st_next = ST_HALT;
        end else if (!sts.pc_ok) begin
          st_next = ST_FAULT;
        end else begin
          cmd.act    = A_FETCH;
          state_next = S_OPLAT;
        end
      end
      S_OPLAT: begin
        cmd.act    = A_OPLAT;
        state_next = S_RDA;
      end
      S_RDA: begin
        cmd.act    = A_RDA;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.act    = A_RDB;
        state_next = S_RDC;
      end
      S_RDC: begin
        cmd.act    = A_RDC;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        st_next    = ST_FAULT;
        case (sts.opc) inside
          OP_CMOV, OP_ADD, OP_MUL, OP_NAND, OP_IN, OP_ORTH: begin
            cmd.act = A_EXEC;
            st_next = ST_RAN;
          end
          OP_OUT: begin
            if (!sts.out_bad) begin
              cmd.act = A_EXEC;
              st_next = ST_RAN;
            end
          end
          OP_INDEX, OP_AMEND: begin
            cmd.act    = A_LENRD;
            state_next = S_CHK;
          end
          OP_LDPRG: begin
            if (sts.vb_zero) begin
              state_next = S_JCHK;
            end else begin
              cmd.act    = A_LENRD;
              state_next = S_CHK;
            end
          end
          OP_DIV: begin
            if (!sts.vc_zero) begin
              cmd.act    = A_DIVST;
              state_next = S_DIV;
            end
          end
          OP_HALT: st_next = ST_HALT;
          OP_NEWARR: begin
            if (!sts.alloc_bad && sts.free_nonempty) begin
              cmd.act    = A_FSRD;
              state_next = S_FSWAIT;
            end else if (!sts.alloc_bad && sts.fresh_avail) begin
              cmd.act    = A_SFRESH;
              state_next = S_ACLR;
            end
          end
          OP_ABAND: begin
            if (!sts.abandon_bad) begin
              cmd.act = A_ABANDON;
              st_next = ST_RAN;
            end
          end
          default: st_next = ST_INVALID;
        endcase
      end
      S_CHK: begin
        state_next = S_DONE;
        st_next    = ST_FAULT;
        case (sts.opc)
          OP_INDEX: begin
            if (sts.slot_ok && sts.off_ok) begin
              cmd.act    = A_RDST;
              state_next = S_RLAT;
            end
          end
          OP_AMEND: begin
            if (sts.slot_ok && sts.off_ok) begin
              cmd.act = A_AMEND;
              st_next = ST_RAN;
            end
          end
          default: begin
            if (sts.slot_ok) begin
              cmd.act    = A_CSET;
              state_next = S_CRD;
            end
          end
        endcase
      end
      S_RLAT: begin
        cmd.act    = A_RDLAT;
        st_next    = ST_RAN;
        state_next = S_DONE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.act    = A_DIVWR;
          st_next    = ST_RAN;
          state_next = S_DONE;
        end else begin
          cmd.act = A_DIV;
        end
      end
      S_FSWAIT: begin
        cmd.act    = A_SPOP;
        state_next = S_ACLR;
      end
      S_ACLR: begin
        if (sts.cnt_done) begin
          cmd.act    = A_ALLOCFN;
          st_next    = ST_RAN;
          state_next = S_DONE;
        end else begin
          cmd.act = A_CLR;
        end
      end
      S_CRD: begin
        if (sts.cnt_done) begin
          cmd.act    = A_CFIN;
          state_next = S_JCHK;
        end else begin
          cmd.act    = A_CRD;
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd.act    = A_CWR;
        state_next = S_CRD;
      end
      S_JCHK: begin
        state_next = S_DONE;
        if (sts.jump_bad) begin
          st_next = ST_FAULT;
        end else begin
          cmd.act = A_JUMP;
          st_next = ST_RAN;
        end
      end
      S_DONE: begin
        if (sts.res_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st_q  <= ST_RAN;
    end else begin
      state <= state_next;
      st_q  <= st_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/array_machine_instruction_executor.sv
// ----------------------------------------------------------------------------
// array_machine_instruction_executor
// 14-operation array machine: program load and single-instruction steps.
// ----------------------------------------------------------------------------
// One transaction in, one result out. A program load, a step on a halted
// machine or a step with the pc past the program ends without a fetch; a
// simple instruction does a store fetch, then reads the three operand
// registers one per cycle; divide makes one quotient bit per cycle; alloc
// clears the slot word by word, popping the free list first when it reuses
// an abandoned slot; load program only jumps when its source is array 0,
// else it copies each word (each word read, then written). A new transaction
// is taken while the previous result still waits.
`default_nettype none
module array_machine_instruction_executor import amie_pkg::*; #(
  parameter int NUM_SLOTS  = 64,
  parameter int SLOT_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [11:0] load_address,
  input  wire logic [31:0] load_word,
  input  wire logic        load_last,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_eof,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [1:0]       status,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             input_taken,
  output logic [11:0]      next_pc
);

  cmd_t cmd;
  sts_t sts;

  amie_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  amie_dp #(.NUM_SLOTS(NUM_SLOTS), .SLOT_WORDS(SLOT_WORDS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .opcode(opcode), .load_address(load_address), .load_word(load_word),
    .load_last(load_last), .in_char(in_char), .in_eof(in_eof),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .out_valid(out_valid), .out_char(out_char),
    .input_taken(input_taken), .next_pc(next_pc)
  );

endmodule
`default_nettype wire

FILE: rtl/amie_checker.sv
// ----------------------------------------------------------------------------
// amie_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module amie_checker import amie_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [1:0]  status,
  input wire logic        out_valid,
  input wire logic        input_taken,
  input wire logic [11:0] next_pc
);

  `AMIE_ASSERT_NXT(a_hold, result_valid && !result_ready, result_valid && $stable(status) && $stable(next_pc) && $stable(out_valid))
  `AMIE_ASSERT_IMP(a_rst_empty, $past(rst), !result_valid)
  `AMIE_ASSERT_IMP(a_out_ran, result_valid && out_valid, status == ST_RAN && !input_taken)
  `AMIE_ASSERT_IMP(a_stop_clean, result_valid && status != ST_RAN, !out_valid && !input_taken)

endmodule

bind array_machine_instruction_executor amie_checker u_chk (.*);
`default_nettype wire
